// ----- hdl/nrmo_pkg.sv -----
// Package for the negacyclic rotate-minus-original block.
// Holds sizes, command codes and the request/response payload types.
// No dependencies.
package nrmo_pkg;

   localparam int POLY_DEGREE = 1024;   // N, a power of two
   localparam int POLY_COUNT  = 2;
   localparam int STORE_DEPTH = POLY_DEGREE * POLY_COUNT;

   localparam int COEF_W = 32;
   localparam int ROT_W  = 11;
   localparam int CMD_W  = 2;

   localparam int LOG_N  = $clog2(POLY_DEGREE);
   localparam int POLY_W = (POLY_COUNT > 1) ? $clog2(POLY_COUNT) : 1;
   localparam int ADDR_W = LOG_N + POLY_W;
   localparam int POS_W  = $clog2(STORE_DEPTH + 1);
   localparam int AMT_W  = LOG_N + 1;
   localparam int ROTX_W = (AMT_W > ROT_W) ? AMT_W : ROT_W;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [COEF_W-1:0] coefficient;
      logic [ROT_W-1:0]         rotation;
   } req_payload_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] difference;
      logic                     last;
   } rsp_payload_type;

endpackage

// ----- hdl/nrmo_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module nrmo_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/negacyclic_rotate_minus_original.sv -----
// Negacyclic rotate-minus-original: emits X^a*p - p in Z[X]/(X^N+1), one word per emit.
// An emit result passes the RAM read register, loaded at the emit's transfer, and then the
// output register, which takes the subtraction. Throughput: one item per cycle while rsp
// drains; set by the single read port of each of the two coefficient RAM copies.
// Reset: load and rotation cleared, emit position parked at end (nothing to emit);
// coefficient RAM contents are not cleared and hold garbage until loaded.
module negacyclic_rotate_minus_original (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  nrmo_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output nrmo_pkg::rsp_payload_type rsp_data
);

   import nrmo_pkg::*;

   // Architectural state
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic [AMT_W-1:0]  rot_amt_ff, rot_amt_in;
   logic [POS_W-1:0]  emit_pos_ff, emit_pos_in;

   // Read stage: RAM data plus the sideband that travels with it
   logic s1_valid_ff, s1_valid_in;
   logic s1_negate_ff, s1_negate_in;
   logic s1_last_ff, s1_last_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic s1_move;
   logic is_load, is_start, do_emit;

   logic [ROTX_W-1:0] rot_wide;
   logic [LOG_N-1:0]  idx;
   logic [LOG_N-1:0]  amt_lo;
   logic [LOG_N-1:0]  rot_idx;
   logic [POLY_W-1:0] poly;
   logic [ADDR_W-1:0] orig_addr, rot_addr;

   logic [COEF_W-1:0] orig_q, rot_q, rot_signed;

   // Advance the read stage whenever the output register is free or draining.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // Hold every request while a read result is stuck behind a stalled output.
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_xfer  = req_valid && !req_stall;

   assign is_load  = req_xfer && (req_data.command == CMD_LOAD);
   assign is_start = req_xfer && (req_data.command == CMD_START);
   assign do_emit  = req_xfer && (req_data.command == CMD_EMIT)
                     && (emit_pos_ff < POS_W'(STORE_DEPTH));

   // Rotation modulo 2N: 2N is a power of two, so keep the low bits.
   assign rot_wide = ROTX_W'(req_data.rotation);

   // Emit position splits into polynomial select and coefficient index.
   assign idx    = emit_pos_ff[LOG_N-1:0];
   assign poly   = emit_pos_ff[LOG_N +: POLY_W];
   assign amt_lo = rot_amt_ff[LOG_N-1:0];
   // Source index wraps mod N in both halves of the rotation range.
   assign rot_idx   = idx - amt_lo;
   assign orig_addr = {poly, idx};
   assign rot_addr  = {poly, rot_idx};

   // Two copies of the store give two reads per cycle; loads write both.
   nrmo_ram #(
      .DATA_W(COEF_W),
      .ADDR_W(ADDR_W)
   ) u_orig_ram (
      .clock  (clock),
      .wr_en  (is_load),
      .wr_addr(load_pos_ff),
      .wr_data(req_data.coefficient),
      .rd_en  (do_emit),
      .rd_addr(orig_addr),
      .rd_data(orig_q)
   );

   nrmo_ram #(
      .DATA_W(COEF_W),
      .ADDR_W(ADDR_W)
   ) u_rot_ram (
      .clock  (clock),
      .wr_en  (is_load),
      .wr_addr(load_pos_ff),
      .wr_data(req_data.coefficient),
      .rd_en  (do_emit),
      .rd_addr(rot_addr),
      .rd_data(rot_q)
   );

   always_comb begin
      load_pos_in = load_pos_ff;
      rot_amt_in  = rot_amt_ff;
      emit_pos_in = emit_pos_ff;

      if (is_load) begin
         // Wrap after the last word so further loads overwrite from the start.
         if (load_pos_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            load_pos_in = '0;
         end else begin
            load_pos_in = load_pos_ff + 1'b1;
         end
      end

      if (is_start) begin
         rot_amt_in  = rot_wide[AMT_W-1:0];
         load_pos_in = '0;
         emit_pos_in = '0;
      end

      if (do_emit) begin
         emit_pos_in = emit_pos_ff + 1'b1;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_negate_in = s1_negate_ff;
      s1_last_in   = s1_last_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (do_emit) begin
         s1_valid_in  = 1'b1;
         // Wrapped source picks up a minus sign; the upper half of a flips it.
         s1_negate_in = (idx < amt_lo) ^ rot_amt_ff[LOG_N];
         s1_last_in   = (emit_pos_ff == POS_W'(STORE_DEPTH - 1));
      end
   end

   assign rot_signed = s1_negate_ff ? (COEF_W'(0) - rot_q) : rot_q;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.difference = rot_signed - orig_q;
         rsp_data_in.last       = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff  <= '0;
         rot_amt_ff   <= '0;
         emit_pos_ff  <= POS_W'(STORE_DEPTH);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_pos_ff  <= load_pos_in;
         rot_amt_ff   <= rot_amt_in;
         emit_pos_ff  <= emit_pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sideband and payload registers need no reset.
   always_ff @(posedge clock) begin
      s1_negate_ff <= s1_negate_in;
      s1_last_ff   <= s1_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Emit counter parks at the end and never runs past it.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_pos_ff <= POS_W'(STORE_DEPTH))
      else $error("emit position beyond end of store");

   // Load pointer stays inside the store.
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff <= ADDR_W'(STORE_DEPTH - 1))
      else $error("load position beyond end of store");

   // A live emit always lands in the read stage on the next cycle.
   a_emit_read: assert property (@(posedge clock) disable iff (reset)
      do_emit |=> s1_valid_ff)
      else $error("emit read lost");

   // A stuck read result is never dropped or overwritten.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff && $stable(s1_last_ff) && $stable(s1_negate_ff))
      else $error("stalled read stage changed");

endmodule

// ----- tb/negacyclic_rotate_minus_original_test.sv -----
// Self-checking testbench for negacyclic_rotate_minus_original: random load, start and emit
// traffic with random idles and stalls, each difference checked against an in-bench predictor.
// Depends on nrmo_pkg (sizes, command codes, payload types) and the block's RTL only.
module negacyclic_rotate_minus_original_test;
   import nrmo_pkg::*;

   // The one command code that the package leaves unnamed; the block must ignore it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int HALF_PERIOD    = 2;
   localparam int ROT_SPAN       = 2 * POLY_DEGREE;   // rotation wraps modulo 2N
   localparam int RANDOM_ITEMS   = 850;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int PRINT_LIMIT    = 40;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   // Both sides idle at random unless this is set; it marks a long stretch at full rate.
   logic            quiet_phase;

   negacyclic_rotate_minus_original uut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   // ---------------------------------------------------------------------------------------
   // Scoreboard: mirrors the coefficient store and the three counters, computes the
   // difference for every accepted emit and queues it until the block returns a result.
   // ---------------------------------------------------------------------------------------
   class difference_scoreboard;
      logic [COEF_W-1:0] coef_store [STORE_DEPTH];
      int unsigned       load_pos;
      int unsigned       rot_amt;
      int unsigned       emit_pos;
      rsp_payload_type   expected_diffs [$];
      int unsigned       failures;
      int unsigned       results_seen;

      function new();
         load_pos     = 0;
         rot_amt      = 0;
         emit_pos     = STORE_DEPTH;   // parked at the end: nothing to emit after reset
         failures     = 0;
         results_seen = 0;
      endfunction

      // Coefficient pos of X^a*p - p, where p is the polynomial that holds pos.
      function logic [COEF_W-1:0] rotated_minus_original(int unsigned pos);
         int unsigned       base;
         int unsigned       i;
         int unsigned       shift;
         logic [COEF_W-1:0] orig;
         logic [COEF_W-1:0] moved;
         base = (pos / POLY_DEGREE) * POLY_DEGREE;
         i    = pos % POLY_DEGREE;
         orig = coef_store[base + i];
         if (rot_amt < POLY_DEGREE) begin
            // Coefficients pushed past X^(N-1) come back around negated.
            shift = rot_amt;
            if (i < shift) moved = -coef_store[base + i + POLY_DEGREE - shift];
            else           moved = coef_store[base + i - shift];
         end else begin
            // X^N = -1: everything is negated once, and the wrapped part twice.
            shift = rot_amt - POLY_DEGREE;
            if (i < shift) moved = coef_store[base + i + POLY_DEGREE - shift];
            else           moved = -coef_store[base + i - shift];
         end
         return moved - orig;
      endfunction

      function void note_transfer(req_payload_type item);
         rsp_payload_type want;
         case (item.command)
            CMD_LOAD: begin
               coef_store[load_pos] = item.coefficient;
               load_pos = (load_pos + 1) % STORE_DEPTH;
            end
            CMD_START: begin
               rot_amt  = item.rotation % ROT_SPAN;
               load_pos = 0;
               emit_pos = 0;
            end
            CMD_EMIT: begin
               if (emit_pos < STORE_DEPTH) begin
                  want.difference = rotated_minus_original(emit_pos);
                  want.last       = (emit_pos == STORE_DEPTH - 1);
                  expected_diffs.push_back(want);
                  emit_pos++;
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         failures++;
         if (failures <= PRINT_LIMIT) $display("result %0d: %s", results_seen, what);
      endtask

      task check_difference(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (expected_diffs.size() == 0) begin
            report_mismatch($sformatf("unexpected result, difference %h", got.difference));
         end else begin
            want = expected_diffs.pop_front();
            if (got.difference !== want.difference)
               report_mismatch($sformatf("difference %h, expected %h",
                                         got.difference, want.difference));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         end
      endtask
   endclass

   difference_scoreboard diffs;

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Fill every field at random; callers then overwrite the ones their command uses.
   function automatic req_payload_type make_request(logic [CMD_W-1:0] cmd);
      req_payload_type item;
      item.command     = cmd;
      item.coefficient = $urandom;
      item.rotation    = ROT_W'($urandom_range(0, (1 << ROT_W) - 1));
      return item;
   endfunction

   // Bias toward the sign and magnitude extremes, where wrapping subtraction goes wrong.
   function automatic logic [COEF_W-1:0] pick_coefficient();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Bias toward the rotations at the wrap points of both halves of the 2N range.
   function automatic logic [ROT_W-1:0] pick_rotation();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ROT_W'(1);
         2:       return ROT_W'(POLY_DEGREE - 1);
         3:       return ROT_W'(POLY_DEGREE);
         4:       return ROT_W'(POLY_DEGREE + 1);
         5:       return ROT_W'(ROT_SPAN - 1);
         default: return ROT_W'($urandom_range(0, ROT_SPAN - 1));
      endcase
   endfunction

   // Drive one item and hold it until the block takes it. Idle cycles drop valid for
   // whole cycles only, so valid is never lowered and raised within one step.
   task automatic send_request(req_payload_type item);
      while (!quiet_phase && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      diffs.note_transfer(item);
   endtask

   task automatic load_word(logic [COEF_W-1:0] coef);
      req_payload_type item;
      item             = make_request(CMD_LOAD);
      item.coefficient = coef;
      send_request(item);
   endtask

   task automatic start_rotation(logic [ROT_W-1:0] amount);
      req_payload_type item;
      item          = make_request(CMD_START);
      item.rotation = amount;
      send_request(item);
   endtask

   task automatic emit_words(int count);
      repeat (count) send_request(make_request(CMD_EMIT));
   endtask

   task automatic send_unused();
      send_request(make_request(CMD_UNUSED));
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: check each transfer, then pick the stall for the next cycle.
   // Values sampled here are the ones that stood before the edge.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) diffs.check_difference(rsp_data);
         rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 10);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [ROT_W-1:0] corner_rotations [6];
      int               counted;
      int               span;
      int               emits;
      int               roll;

      corner_rotations = '{ROT_W'(0), ROT_W'(1), ROT_W'(POLY_DEGREE - 1),
                           ROT_W'(POLY_DEGREE), ROT_W'(POLY_DEGREE + 1),
                           ROT_W'(ROT_SPAN - 1)};
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      quiet_phase = 1'b0;
      diffs       = new();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole store before any emit, since unwritten words hold garbage.
      // Run three loads past the end so the load position wraps and overwrites the start.
      for (int k = 0; k < STORE_DEPTH + 3; k++) load_word(pick_coefficient());

      // Hit each wrap point of the rotation with a few emits.
      foreach (corner_rotations[r]) begin
         start_rotation(corner_rotations[r]);
         emit_words(3);
      end

      // Start rewinds the load position: overwrite the first words, then read them back.
      start_rotation('0);
      load_word(32'h8000_0000);
      load_word(32'h7fff_ffff);
      emit_words(3);

      send_unused();

      // One full pass: reach the final word of the last polynomial, then emit past the end.
      start_rotation(pick_rotation());
      emit_words(STORE_DEPTH + 2);

      // Random sequences: mostly start, a few loads, a run of emits with loads mixed in;
      // now and then a full pass, and some noise. Runs cut short are the broken sequences.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         quiet_phase <= (counted >= 300 && counted < 500);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            repeat ($urandom_range(1, 3)) send_unused();
            emits = $urandom_range(0, 2);
            emit_words(emits);
            counted += emits;
         end else begin
            start_rotation(pick_rotation());
            span = $urandom_range(0, 6);
            repeat (span) load_word(pick_coefficient());
            counted += 1 + span;
            if (roll < 13) emits = STORE_DEPTH + $urandom_range(0, 2);
            else           emits = $urandom_range(1, 48);
            for (int k = 0; k < emits; k++) begin
               if ($urandom_range(0, 19) == 0) begin
                  load_word(pick_coefficient());
                  counted++;
               end
               if ($urandom_range(0, 49) == 0) send_unused();
               emit_words(1);
            end
            counted += emits;
         end
      end

      // Drain: wait for every outstanding difference, then wait DRAIN_CYCLES for strays.
      req_valid <= 1'b0;
      while (diffs.expected_diffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (diffs.failures == 0) begin
         $display("negacyclic_rotate_minus_original: match");
      end else begin
         $display("negacyclic_rotate_minus_original: mismatch");
      end
      $finish;
   end

   // Stop a hung run well past the slowest correct one.
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("negacyclic_rotate_minus_original: mismatch");
      $finish;
   end

endmodule
